@@ rtl/rebd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the rotary encoder and button decoder.
// No dependencies; imported by every module of the block.
package rebd_pkg;

    // Configuration register map
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned PERIOD_W   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ENC_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BTN_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE = 2'd2;

    // Reset values of the configuration registers
    localparam logic [PERIOD_W-1:0] ENC_PERIOD_RST = 8'd2;
    localparam logic [PERIOD_W-1:0] BTN_PERIOD_RST = 8'd13;

    // Decode modes
    localparam logic MODE_ARM_COMPLETE = 1'b0;
    localparam logic MODE_ABSOLUTE     = 1'b1;

    // Absolute mode phase codes {a, b}
    localparam logic [1:0] PHASE_REST  = 2'b00;
    localparam logic [1:0] PHASE_LEFT  = 2'b01;
    localparam logic [1:0] PHASE_RIGHT = 2'b10;

    // Input word: one timer tick with the pin levels
    typedef struct packed {
        logic phase_a_level;
        logic phase_b_level;
        logic button_level;
    } rebd_in_t;

    // Result word: event flags for this tick
    typedef struct packed {
        logic step_left;
        logic step_right;
        logic button_pressed;
        logic button_released;
    } rebd_out_t;

    // Configuration as seen by the decode core
    typedef struct packed {
        logic [PERIOD_W-1:0] enc_period;
        logic [PERIOD_W-1:0] btn_period;
        logic                decode_mode;
    } rebd_cfg_t;

endpackage

@@ rtl/rebd_core.sv @@
`timescale 1ns / 1ps
// Decode core: tick counters, encoder arm/step logic and button edge logic.
// Depends on rebd_pkg. State advances once per accepted word.
module rebd_core
    import rebd_pkg::*;
#(
    parameter int unsigned TICK_COUNT_BITS = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      accept,
    input  rebd_in_t  in_word,
    input  rebd_cfg_t cfg,
    output rebd_out_t result
);

    localparam int unsigned CMP_W = (TICK_COUNT_BITS > PERIOD_W) ? TICK_COUNT_BITS : PERIOD_W;

    logic [TICK_COUNT_BITS-1:0] enc_cnt_reg, enc_cnt_next;
    logic [TICK_COUNT_BITS-1:0] btn_cnt_reg, btn_cnt_next;
    logic                       left_armed_reg, left_armed_next;
    logic                       right_armed_reg, right_armed_next;
    logic                       held_reg, held_next;
    logic [1:0]                 prev_phase_reg, prev_phase_next;

    logic [TICK_COUNT_BITS-1:0] enc_inc, btn_inc;
    logic                       enc_check, btn_check;
    logic                       a, b, btn;
    logic                       la1, ra1, la2;
    logic                       arm_step_l, arm_step_r;
    logic [1:0]                 phase;

    assign a   = in_word.phase_a_level;
    assign b   = in_word.phase_b_level;
    assign btn = in_word.button_level;

    // Counters wrap within their width, then compare against the period
    assign enc_inc   = enc_cnt_reg + 1'b1;
    assign btn_inc   = btn_cnt_reg + 1'b1;
    assign enc_check = CMP_W'(enc_inc) >= CMP_W'(cfg.enc_period);
    assign btn_check = CMP_W'(btn_inc) >= CMP_W'(cfg.btn_period);

    // Arm-and-complete: left rules first, right rules see updated left flag
    assign la1        = left_armed_reg | (!a && b && !left_armed_reg && !right_armed_reg);
    assign arm_step_l = a && b && la1 && !right_armed_reg;
    assign la2        = arm_step_l ? 1'b0 : la1;
    assign ra1        = right_armed_reg | (!b && a && !right_armed_reg && !la2);
    assign arm_step_r = b && a && ra1 && !la2;

    assign phase = {a, b};

    // Next state and this tick's flags
    always_comb begin
        enc_cnt_next     = enc_check ? '0 : enc_inc;
        btn_cnt_next     = btn_check ? '0 : btn_inc;
        left_armed_next  = left_armed_reg;
        right_armed_next = right_armed_reg;
        prev_phase_next  = prev_phase_reg;
        held_next        = held_reg;
        result           = '0;

        if (enc_check) begin
            if (cfg.decode_mode == MODE_ARM_COMPLETE) begin
                result.step_left  = arm_step_l;
                result.step_right = arm_step_r;
                left_armed_next   = la2;
                right_armed_next  = arm_step_r ? 1'b0 : ra1;
            end else begin
                result.step_left  = (phase == PHASE_REST) && (prev_phase_reg == PHASE_LEFT);
                result.step_right = (phase == PHASE_REST) && (prev_phase_reg == PHASE_RIGHT);
                prev_phase_next   = phase;
            end
        end

        if (btn_check) begin
            result.button_pressed  = !btn && !held_reg;
            result.button_released = btn && held_reg;
            held_next              = !btn;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enc_cnt_reg     <= '0;
            btn_cnt_reg     <= '0;
            left_armed_reg  <= 1'b0;
            right_armed_reg <= 1'b0;
            held_reg        <= 1'b0;
            prev_phase_reg  <= PHASE_REST;
        end else if (accept) begin
            enc_cnt_reg     <= enc_cnt_next;
            btn_cnt_reg     <= btn_cnt_next;
            left_armed_reg  <= left_armed_next;
            right_armed_reg <= right_armed_next;
            held_reg        <= held_next;
            prev_phase_reg  <= prev_phase_next;
        end
    end

endmodule

@@ rtl/rotary_encoder_button_decoder_unit.sv @@
`timescale 1ns / 1ps
// Rotary encoder and push-button decoder, top level.
// Result word: registered into the output register, or, while that one waits
// on m_ready, into the skid register. Throughput: one word per cycle while the
// skid register is empty, so input stays accepted while one result waits.
// Reset: synchronous active-low aresetn clears counters and flags and loads
// the default config (periods 2 and 13, arm-and-complete mode).
// Depends on rebd_pkg and rebd_core.
module rotary_encoder_button_decoder_unit
    import rebd_pkg::*;
#(
    parameter int unsigned TICK_COUNT_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rebd_in_t              s_data,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output rebd_out_t             m_data
);

    rebd_cfg_t cfg_reg;
    rebd_out_t core_result;
    rebd_out_t out_reg, skid_reg;
    logic      out_valid_reg, skid_valid_reg;
    logic      accept, pop;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enc_period  <= ENC_PERIOD_RST;
            cfg_reg.btn_period  <= BTN_PERIOD_RST;
            cfg_reg.decode_mode <= MODE_ARM_COMPLETE;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_ENC_PERIOD:  cfg_reg.enc_period  <= cfg_wdata[PERIOD_W-1:0];
                REG_BTN_PERIOD:  cfg_reg.btn_period  <= cfg_wdata[PERIOD_W-1:0];
                REG_DECODE_MODE: cfg_reg.decode_mode <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    rebd_core #(
        .TICK_COUNT_BITS(TICK_COUNT_BITS)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .accept (accept),
        .in_word(s_data),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    // Output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_reg       <= core_result;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= core_result;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

@@ rtl/rebd_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the encoder/button decoder, bound to the top level.
// Depends on rebd_pkg and rotary_encoder_button_decoder_unit.
module rebd_checker
    import rebd_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input rebd_out_t m_data
);

    // no result word straight out of reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one detent direction per tick (exclusive arm flags; one previous phase in absolute mode)
    a_one_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.step_left && m_data.step_right))
        else $error("left and right step in one word");

    // button edge flags are exclusive
    a_one_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.button_pressed && m_data.button_released))
        else $error("press and release in one word");

    // input stalls only when a result is backed up
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

endmodule

bind rotary_encoder_button_decoder_unit rebd_checker u_rebd_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
